// File: sv/rae_pkg.sv
// Shared types, encodings and constants for the R-type ALU execute unit.
package rae_pkg;

    localparam int unsigned XLEN     = 32;
    localparam int unsigned SHAMT_W  = 5;
    localparam int unsigned DIV_STEPS = XLEN;
    localparam int unsigned CNT_W    = $clog2(DIV_STEPS);

    // funct3 codes
    localparam logic [2:0] F3_ADD_SUB_MUL = 3'b000;
    localparam logic [2:0] F3_SLL         = 3'b001;
    localparam logic [2:0] F3_SLT         = 3'b010;
    localparam logic [2:0] F3_XOR_DIV     = 3'b100;
    localparam logic [2:0] F3_SRL_SRA     = 3'b101;
    localparam logic [2:0] F3_OR_REM      = 3'b110;
    localparam logic [2:0] F3_AND         = 3'b111;

    // funct7 codes
    localparam logic [6:0] F7_BASE   = 7'b0000000;
    localparam logic [6:0] F7_ALT    = 7'b0100000;
    localparam logic [6:0] F7_MULDIV = 7'b0000001;

    typedef enum logic [3:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_SLL,
        ALU_SLT,
        ALU_XOR,
        ALU_DIV,
        ALU_SRL,
        ALU_SRA,
        ALU_OR,
        ALU_REM,
        ALU_AND,
        ALU_BAD
    } alu_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_FIX,
        ST_WRITE
    } rae_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic div_step;
        logic div_fix;
        logic write;
    } rae_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_divrem;
        logic b_zero;
        logic div_last;
    } rae_status_t;

    function automatic alu_op_t decode_op(input logic [2:0] f3, input logic [6:0] f7);
        alu_op_t op;
        op = ALU_BAD;
        case (f3)
            F3_ADD_SUB_MUL:
            begin
                if (f7 == F7_BASE)        op = ALU_ADD;
                else if (f7 == F7_ALT)    op = ALU_SUB;
                else if (f7 == F7_MULDIV) op = ALU_MUL;
            end
            F3_SLL:
            begin
                if (f7 == F7_BASE) op = ALU_SLL;
            end
            F3_SLT:
            begin
                if (f7 == F7_BASE) op = ALU_SLT;
            end
            F3_XOR_DIV:
            begin
                if (f7 == F7_BASE)        op = ALU_XOR;
                else if (f7 == F7_MULDIV) op = ALU_DIV;
            end
            F3_SRL_SRA:
            begin
                if (f7 == F7_BASE)     op = ALU_SRL;
                else if (f7 == F7_ALT) op = ALU_SRA;
            end
            F3_OR_REM:
            begin
                if (f7 == F7_BASE)        op = ALU_OR;
                else if (f7 == F7_MULDIV) op = ALU_REM;
            end
            F3_AND:
            begin
                if (f7 == F7_BASE) op = ALU_AND;
            end
            default:
            begin
                op = ALU_BAD;
            end
        endcase
        return op;
    endfunction

endpackage

// File: sv/rae_ctrl.sv
// Sequencing state machine of the R-type ALU execute unit.
module rae_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  rae_pkg::rae_status_t status,
    output rae_pkg::rae_cmd_t    cmd
);

    rae_pkg::rae_state_t state_reg;
    rae_pkg::rae_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;

    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rae_pkg::ST_IDLE:
            begin
                if (in_valid) state_next = rae_pkg::ST_EXEC;
            end
            rae_pkg::ST_EXEC:
            begin
                if (status.is_divrem && !status.b_zero) state_next = rae_pkg::ST_DIV;
                else                                    state_next = rae_pkg::ST_WRITE;
            end
            rae_pkg::ST_DIV:
            begin
                if (status.div_last) state_next = rae_pkg::ST_FIX;
            end
            rae_pkg::ST_FIX:
            begin
                state_next = rae_pkg::ST_WRITE;
            end
            rae_pkg::ST_WRITE:
            begin
                if (out_free) state_next = rae_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rae_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            rae_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            rae_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            rae_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            rae_pkg::ST_FIX:
            begin
                cmd.div_fix = 1'b1;
            end
            rae_pkg::ST_WRITE:
            begin
                cmd.write = out_free;
                if (out_free) out_valid_next = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rae_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: sv/rae_datapath.sv
// Operand registers, ALU, multiplier, radix-2 divider and output register.
module rae_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rae_pkg::rae_cmd_t          cmd,
    output rae_pkg::rae_status_t       status,
    input  logic [2:0]                 mode,
    input  logic [6:0]                 mode_variant,
    input  logic [rae_pkg::XLEN-1:0]   operand_a,
    input  logic [rae_pkg::XLEN-1:0]   operand_b,
    output logic [rae_pkg::XLEN-1:0]   result,
    output logic                       unknown_op,
    output logic                       divide_by_zero
);

    localparam int unsigned W = rae_pkg::XLEN;

    rae_pkg::alu_op_t   op_reg, op_next;
    logic [W-1:0]       a_reg, a_next;
    logic [W-1:0]       b_reg, b_next;
    logic [W-1:0]       res_reg, res_next;
    logic               dz_reg, dz_next;
    logic               unk_reg, unk_next;
    logic [W-1:0]       quo_reg, quo_next;
    logic [W-1:0]       rem_reg, rem_next;
    logic [W-1:0]       dvsr_reg, dvsr_next;
    logic               neg_q_reg, neg_q_next;
    logic               neg_r_reg, neg_r_next;
    logic [rae_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]       last_reg, last_next;
    logic [W-1:0]       result_reg;
    logic               unknown_op_reg;
    logic               divide_by_zero_reg;

    logic [2*W-1:0]     prod_full;
    logic [W-1:0]       mag_a;
    logic [W-1:0]       mag_b;
    logic [rae_pkg::SHAMT_W-1:0] shamt;
    logic [W:0]         rem_shift;
    logic [W:0]         diff;

    assign prod_full = a_reg * b_reg;
    assign mag_a     = a_reg[W-1] ? (W'(0) - a_reg) : a_reg;
    assign mag_b     = b_reg[W-1] ? (W'(0) - b_reg) : b_reg;
    assign shamt     = b_reg[rae_pkg::SHAMT_W-1:0];
    assign rem_shift = {rem_reg, quo_reg[W-1]};
    assign diff      = rem_shift - {1'b0, dvsr_reg};

    assign status.is_divrem = (op_reg == rae_pkg::ALU_DIV) || (op_reg == rae_pkg::ALU_REM);
    assign status.b_zero    = (b_reg == '0);
    assign status.div_last  = (cnt_reg == '0);

    always_comb
    begin
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        res_next   = res_reg;
        dz_next    = dz_reg;
        unk_next   = unk_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvsr_next  = dvsr_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;

        if (cmd.load)
        begin
            op_next = rae_pkg::decode_op(mode, mode_variant);
            a_next  = operand_a;
            b_next  = operand_b;
        end

        if (cmd.exec)
        begin
            dz_next  = 1'b0;
            unk_next = 1'b0;
            case (op_reg)
                rae_pkg::ALU_ADD: res_next = a_reg + b_reg;
                rae_pkg::ALU_SUB: res_next = a_reg - b_reg;
                rae_pkg::ALU_MUL: res_next = prod_full[W-1:0];
                rae_pkg::ALU_SLL: res_next = a_reg << shamt;
                rae_pkg::ALU_SLT: res_next = W'($signed(a_reg) < $signed(b_reg));
                rae_pkg::ALU_XOR: res_next = a_reg ^ b_reg;
                rae_pkg::ALU_SRL: res_next = a_reg >> shamt;
                rae_pkg::ALU_SRA: res_next = W'($signed(a_reg) >>> shamt);
                rae_pkg::ALU_OR:  res_next = a_reg | b_reg;
                rae_pkg::ALU_AND: res_next = a_reg & b_reg;
                rae_pkg::ALU_DIV, rae_pkg::ALU_REM:
                begin
                    if (b_reg == '0)
                    begin
                        // zero divisor: all ones for div, dividend for rem
                        res_next = (op_reg == rae_pkg::ALU_DIV) ? '1 : a_reg;
                        dz_next  = 1'b1;
                    end
                    else
                    begin
                        quo_next   = mag_a;
                        rem_next   = '0;
                        dvsr_next  = mag_b;
                        neg_q_next = a_reg[W-1] ^ b_reg[W-1];
                        neg_r_next = a_reg[W-1];
                        cnt_next   = rae_pkg::CNT_W'(rae_pkg::DIV_STEPS - 1);
                    end
                end
                default:
                begin
                    res_next = last_reg;
                    unk_next = 1'b1;
                end
            endcase
        end

        if (cmd.div_step)
        begin
            // one restoring step: shift in the next dividend bit, try subtract
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end

        if (cmd.div_fix)
        begin
            if (op_reg == rae_pkg::ALU_DIV)
                res_next = neg_q_reg ? (W'(0) - quo_reg) : quo_reg;
            else
                res_next = neg_r_reg ? (W'(0) - rem_reg) : rem_reg;
        end

        if (cmd.write)
        begin
            last_next = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            last_reg <= last_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        res_reg   <= res_next;
        dz_reg    <= dz_next;
        unk_reg   <= unk_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dvsr_reg  <= dvsr_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
        if (cmd.write)
        begin
            result_reg         <= res_reg;
            unknown_op_reg     <= unk_reg;
            divide_by_zero_reg <= dz_reg;
        end
    end

    assign result         = result_reg;
    assign unknown_op     = unknown_op_reg;
    assign divide_by_zero = divide_by_zero_reg;

endmodule

// File: sv/rtype_alu_execute_unit.sv
// Top level of the R-type ALU execute unit for a subset of RV32IM.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_ready  | mode, mode_variant, operand_a, operand_b
//  output   | out_valid / out_ready| result, unknown_op, divide_by_zero
//
// One item at a time. add, sub, mul, shifts, slt and logic ops go through accept,
// execute and write on the way to the output register. div and rem go through
// accept, setup, 32 radix-2 divider steps, sign fixup and write; a zero divisor
// skips the divider and the fixup and goes from setup straight to write.
// Reset clears the controller, the output valid and the last-result register.
// A full output register stalls only the write step; a new item is taken while
// the previous result still waits on out_ready.
module rtype_alu_execute_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          mode,
    input  logic [6:0]          mode_variant,
    input  logic signed [31:0]  operand_a,
    input  logic signed [31:0]  operand_b,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  result,
    output logic                unknown_op,
    output logic                divide_by_zero
);

    rae_pkg::rae_cmd_t    cmd;
    rae_pkg::rae_status_t status;
    logic [31:0]          result_raw;

    // sequence the item: load, execute, iterate divider, fix signs, write
    rae_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // hold operands, compute, and keep the result until taken
    rae_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .mode           (mode),
        .mode_variant   (mode_variant),
        .operand_a      (operand_a),
        .operand_b      (operand_b),
        .result         (result_raw),
        .unknown_op     (unknown_op),
        .divide_by_zero (divide_by_zero)
    );

    assign result = result_raw;

endmodule
